/* hw/rtl/gwt_pkg.sv */
// Shared constants, register indexes and helper functions for the grid window tiler.
`timescale 1ns / 1ps

package gwt_pkg;

    localparam int unsigned MAX_WINDOWS_DEF = 64;

    localparam int unsigned AREA_W  = 14;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned BDR_W   = 8;
    localparam int unsigned POS_W   = 15;
    localparam int unsigned CFG_IDX_W = 2;

    // largest grid side for a 7-bit count (12 * 12 >= 127)
    localparam int unsigned ROWS_MAX = 12;
    localparam int unsigned ROWS_W   = 4;

    // reciprocal scaling: exact floor division of a 14-bit value by 1..12
    localparam int unsigned RECIP_SHIFT = AREA_W + ROWS_W;
    localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

    localparam logic [AREA_W-1:0] AREA_W_RST = AREA_W'(1920);
    localparam logic [AREA_W-1:0] AREA_H_RST = AREA_W'(1080);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AREA_X = 2'd0,
        REG_AREA_Y = 2'd1,
        REG_AREA_WIDTH = 2'd2,
        REG_AREA_HEIGHT = 2'd3
    } t_cfg_reg;

    // smallest r >= 1 with r*r >= n
    function automatic logic [ROWS_W-1:0] grid_rows(input logic [CNT_W-1:0] n);
        logic [ROWS_W-1:0] r;
        r = ROWS_W'(1);
        for (int unsigned k = 1; k < ROWS_MAX; k++) begin
            if ((k * k) < 32'(n)) begin
                r = r + ROWS_W'(1);
            end
        end
        return r;
    endfunction

    // ceil(2^RECIP_SHIFT / d)
    function automatic logic [RECIP_W-1:0] recip(input logic [ROWS_W-1:0] d);
        logic [RECIP_W-1:0] m;
        unique case (d)
            4'd1:    m = RECIP_W'(262144);
            4'd2:    m = RECIP_W'(131072);
            4'd3:    m = RECIP_W'(87382);
            4'd4:    m = RECIP_W'(65536);
            4'd5:    m = RECIP_W'(52429);
            4'd6:    m = RECIP_W'(43691);
            4'd7:    m = RECIP_W'(37450);
            4'd8:    m = RECIP_W'(32768);
            4'd9:    m = RECIP_W'(29128);
            4'd10:   m = RECIP_W'(26215);
            4'd11:   m = RECIP_W'(23832);
            4'd12:   m = RECIP_W'(21846);
            default: m = RECIP_W'(262144);
        endcase
        return m;
    endfunction

endpackage

/* hw/rtl/grid_window_tiling.sv */
// Top level of the grid window tiler: five-stage placement pipeline.
// Throughput: one item per cycle unless a stalled result holds the pipeline.
// The reciprocal multipliers in stage two, the remainder multipliers in stage
// three and the row offset multiplier in stage four set the stage depth.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and loads the area
// registers with 0, 0, 1920, 1080.
`timescale 1ns / 1ps

module grid_window_tiling #(
    parameter int unsigned MAX_WINDOWS = gwt_pkg::MAX_WINDOWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gwt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gwt_pkg::AREA_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [gwt_pkg::CNT_W-1:0]     i_window_count,
    input  logic [gwt_pkg::IDX_W-1:0]     i_window_index,
    input  logic [gwt_pkg::BDR_W-1:0]     i_border_width,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gwt_pkg::POS_W-1:0]     o_pos_x,
    output logic [gwt_pkg::POS_W-1:0]     o_pos_y,
    output logic [gwt_pkg::AREA_W-1:0]    o_size_w,
    output logic [gwt_pkg::AREA_W-1:0]    o_size_h,
    output logic                          o_index_error
);

    localparam int unsigned AW = gwt_pkg::AREA_W;
    localparam int unsigned RW = gwt_pkg::ROWS_W;
    localparam int unsigned MW = gwt_pkg::RECIP_W;
    localparam int unsigned SH = gwt_pkg::RECIP_SHIFT;
    localparam int unsigned IW = gwt_pkg::IDX_W;
    localparam int unsigned CW = gwt_pkg::CNT_W;
    localparam int unsigned PW = gwt_pkg::POS_W;
    localparam int unsigned BW = gwt_pkg::BDR_W;
    localparam int unsigned CNT_CAP =
        (MAX_WINDOWS < ((1 << CW) - 1)) ? MAX_WINDOWS : ((1 << CW) - 1);
    localparam logic [CW-1:0] CAP = CW'(CNT_CAP);

    // configuration registers
    logic [AW-1:0] r_area_x, r_area_y, r_area_w, r_area_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_x <= '0;
            r_area_y <= '0;
            r_area_w <= gwt_pkg::AREA_W_RST;
            r_area_h <= gwt_pkg::AREA_H_RST;
        end else if (i_cfg_we) begin
            unique case (gwt_pkg::t_cfg_reg'(i_cfg_index))
                gwt_pkg::REG_AREA_X:      r_area_x <= i_cfg_data;
                gwt_pkg::REG_AREA_Y:      r_area_y <= i_cfg_data;
                gwt_pkg::REG_AREA_WIDTH:  r_area_w <= i_cfg_data;
                gwt_pkg::REG_AREA_HEIGHT: r_area_h <= i_cfg_data;
            endcase
        end
    end

    logic adv;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    assign adv        = !(r_v5 && i_out_stall);
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1: clamp count, grid shape, error flag
    logic [CW-1:0]   n_cnt;
    logic [RW-1:0]   n_rows, n_cols;
    logic [2*RW-1:0] n_rr;
    logic            n_err;

    always_comb begin
        n_cnt  = (i_window_count > CAP) ? CAP : i_window_count;
        n_err  = (n_cnt == '0) || ({1'b0, i_window_index} >= n_cnt);
        n_rows = gwt_pkg::grid_rows(n_cnt);
        n_rr   = (n_rows - RW'(1)) * n_rows;
        n_cols = (n_rr >= (2*RW)'(n_cnt)) ? (n_rows - RW'(1)) : n_rows;
    end

    logic [IW-1:0] r1_idx;
    logic [BW-1:0] r1_bw;
    logic          r1_err;
    logic [RW-1:0] r1_rows, r1_cols;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_idx  <= i_window_index;
            r1_bw   <= i_border_width;
            r1_err  <= n_err;
            r1_rows <= n_rows;
            r1_cols <= n_cols;
        end
    end

    // stage 2: quotients through reciprocal multiply
    logic [MW-1:0]    n_m_r, n_m_c;
    logic [AW+MW-1:0] n_ph, n_pw;
    logic [IW+MW-1:0] n_pi;
    logic [2*RW-1:0]  n_lc_thr;
    logic             n_lastcol;

    always_comb begin
        n_m_r     = gwt_pkg::recip(r1_rows);
        n_m_c     = gwt_pkg::recip(r1_cols);
        n_ph      = {{MW{1'b0}}, r_area_h} * {{AW{1'b0}}, n_m_r};
        n_pw      = {{MW{1'b0}}, r_area_w} * {{AW{1'b0}}, n_m_c};
        n_pi      = {{MW{1'b0}}, r1_idx} * {{IW{1'b0}}, n_m_r};
        n_lc_thr  = r1_rows * (r1_cols - RW'(1));
        n_lastcol = ((2*RW)'(r1_idx) >= n_lc_thr);
    end

    logic [AW-1:0] r2_ch, r2_cw;
    logic [IW-1:0] r2_ci, r2_idx;
    logic [BW-1:0] r2_bw;
    logic          r2_err, r2_lastcol;
    logic [RW-1:0] r2_rows, r2_cols;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_ch      <= n_ph[SH+AW-1:SH];
            r2_cw      <= n_pw[SH+AW-1:SH];
            r2_ci      <= n_pi[SH+IW-1:SH];
            r2_idx     <= r1_idx;
            r2_bw      <= r1_bw;
            r2_err     <= r1_err;
            r2_lastcol <= n_lastcol;
            r2_rows    <= r1_rows;
            r2_cols    <= r1_cols;
        end
    end

    // stage 3: remainders, row within column, column offset
    logic [AW+RW-1:0] n_chr, n_cwc;
    logic [IW+RW-1:0] n_cir;
    logic [IW+AW-1:0] n_xoff;
    logic [IW-1:0]    n_irow;

    always_comb begin
        n_chr  = r2_ch * {{(AW-RW){1'b0}}, r2_rows};
        n_cwc  = r2_cw * {{(AW-RW){1'b0}}, r2_cols};
        n_cir  = r2_ci * {{(IW-RW){1'b0}}, r2_rows};
        n_xoff = {{AW{1'b0}}, r2_ci} * {{IW{1'b0}}, r2_cw};
        n_irow = r2_idx - n_cir[IW-1:0];
    end

    logic [AW-1:0] r3_remh, r3_remw, r3_ch, r3_cw;
    logic [RW-1:0] r3_irow, r3_rows;
    logic [PW-1:0] r3_xoff;
    logic [BW-1:0] r3_bw;
    logic          r3_err, r3_lastcol;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_remh    <= r_area_h - n_chr[AW-1:0];
            r3_remw    <= r_area_w - n_cwc[AW-1:0];
            r3_ch      <= r2_ch;
            r3_cw      <= r2_cw;
            r3_irow    <= n_irow[RW-1:0];
            r3_rows    <= r2_rows;
            r3_xoff    <= n_xoff[PW-1:0];
            r3_bw      <= r2_bw;
            r3_err     <= r2_err;
            r3_lastcol <= r2_lastcol;
        end
    end

    // stage 4: row offset, cell sizes with remainders
    logic [AW+RW-1:0] n_yoff;
    logic             n_lastrow;

    always_comb begin
        n_yoff    = r3_ch * {{(AW-RW){1'b0}}, r3_irow};
        n_lastrow = (r3_irow == (r3_rows - RW'(1)));
    end

    logic [PW-1:0] r4_xoff, r4_yoff;
    logic [AW-1:0] r4_tot_w, r4_tot_h;
    logic [BW-1:0] r4_bw;
    logic          r4_err;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_xoff  <= r3_xoff;
            r4_yoff  <= PW'(n_yoff);
            r4_tot_w <= r3_cw + (r3_lastcol ? r3_remw : '0);
            r4_tot_h <= r3_ch + (n_lastrow ? r3_remh : '0);
            r4_bw    <= r3_bw;
            r4_err   <= r3_err;
        end
    end

    // stage 5: add area origin, take off borders, error override
    logic [BW:0]   n_cut;
    logic [PW-1:0] n_px, n_py;
    logic [AW-1:0] n_sw, n_sh;

    always_comb begin
        n_cut = {r4_bw, 1'b0};
        n_px  = PW'(r_area_x) + r4_xoff;
        n_py  = PW'(r_area_y) + r4_yoff;
        n_sw  = (r4_tot_w <= AW'(n_cut)) ? AW'(1) : (r4_tot_w - AW'(n_cut));
        n_sh  = (r4_tot_h <= AW'(n_cut)) ? AW'(1) : (r4_tot_h - AW'(n_cut));
        if (r4_err) begin
            n_px = '0;
            n_py = '0;
            n_sw = AW'(1);
            n_sh = AW'(1);
        end
    end

    logic [PW-1:0] r_pos_x, r_pos_y;
    logic [AW-1:0] r_size_w, r_size_h;
    logic          r_err;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pos_x  <= n_px;
            r_pos_y  <= n_py;
            r_size_w <= n_sw;
            r_size_h <= n_sh;
            r_err    <= r4_err;
        end
    end

    assign o_out_valid   = r_v5;
    assign o_pos_x       = r_pos_x;
    assign o_pos_y       = r_pos_y;
    assign o_size_w      = r_size_w;
    assign o_size_h      = r_size_h;
    assign o_index_error = r_err;

endmodule

/* hw/rtl/gwt_checker.sv */
// Port-level assertions for the grid window tiler and their bind.
`timescale 1ns / 1ps

module gwt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [gwt_pkg::POS_W-1:0]     o_pos_x,
    input logic [gwt_pkg::POS_W-1:0]     o_pos_y,
    input logic [gwt_pkg::AREA_W-1:0]    o_size_w,
    input logic [gwt_pkg::AREA_W-1:0]    o_size_h,
    input logic                          o_index_error
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_pos_x) && $stable(o_pos_y)
            && $stable(o_size_w) && $stable(o_size_h) && $stable(o_index_error))
        else $error("stalled result changed");

    // input side only stalls behind a waiting result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a waiting result");

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_index_error |-> (o_pos_x == '0) && (o_pos_y == '0)
            && (o_size_w == gwt_pkg::AREA_W'(1)) && (o_size_h == gwt_pkg::AREA_W'(1)))
        else $error("error result carries placement");

    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid straight after reset");

endmodule

bind grid_window_tiling gwt_checker u_gwt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_pos_x       (o_pos_x),
    .o_pos_y       (o_pos_y),
    .o_size_w      (o_size_w),
    .o_size_h      (o_size_h),
    .o_index_error (o_index_error)
);
